/* src/time_and_calendar_counter_macros.svh */
// Assertion helpers for the RTL that checks itself.
// Each expects clk and rst_n in scope and is disabled while reset is low.
`ifndef TIME_AND_CALENDAR_COUNTER_MACROS_SVH
`define TIME_AND_CALENDAR_COUNTER_MACROS_SVH

// Same-cycle implication.
`define RTCC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtcc assertion failed");

// Next-cycle implication.
`define RTCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtcc assertion failed");

`endif

/* src/rtcc_pkg.sv */
`default_nettype none

package rtcc_pkg;

    localparam int YEAR_MAX_WIDTH   = 16;
    localparam int SET_YEAR_WIDTH   = 14;
    localparam int YEAR_RESET_VALUE = 1996;

    localparam logic [4:0] HOUR_MAX      = 5'd23;
    localparam logic [5:0] MINUTE_MAX    = 6'd59;
    localparam logic [5:0] SECOND_MAX    = 6'd59;
    localparam logic [3:0] MONTH_FIRST   = 4'd1;
    localparam logic [3:0] MONTH_FEB     = 4'd2;
    localparam logic [3:0] MONTH_MAX     = 4'd12;
    localparam logic [4:0] DAY_FIRST     = 5'd1;
    localparam logic [4:0] DAYS_DEFAULT  = 5'd31;
    localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;

    // Divisibility by 25 via the multiplicative inverse mod 2^16:
    // y is a multiple of 25 exactly when y * inv (mod 2^16) <= (2^16 - 1) / 25.
    localparam logic [15:0] DIV25_INV   = 16'h5C29;
    localparam logic [15:0] DIV25_LIMIT = 16'd2621;

    localparam int MONTH_SLOTS = 13;
    localparam logic [4:0] MONTH_DAYS [0:MONTH_SLOTS-1] = '{
        5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef enum logic {
        MODE_TICK = 1'b0,
        MODE_LOAD = 1'b1
    } mode_t;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [3:0] month;
        logic [4:0] day;
    } rtcc_time_t;

    typedef struct packed {
        mode_t                     mode;
        rtcc_time_t                tm;
        logic [SET_YEAR_WIDTH-1:0] year;
    } rtcc_item_t;

    // Gregorian leap test: multiple of 4 and not of 100, or multiple of 400.
    // A multiple of 100 is a multiple of 4 and 25; of 400, of 16 and 25.
    function automatic logic is_leap(input logic [YEAR_MAX_WIDTH-1:0] year);
        logic [YEAR_MAX_WIDTH-1:0] prod;
        logic                      div4;
        logic                      div16;
        logic                      div25;
        prod  = year * DIV25_INV;
        div4  = (year[1:0] == 2'd0);
        div16 = (year[3:0] == 4'd0);
        div25 = (prod <= DIV25_LIMIT);
        return div4 && (!div25 || div16);
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        len = DAYS_DEFAULT;
        if (month >= MONTH_FIRST && month <= MONTH_MAX) begin
            if (month == MONTH_FEB && leap)
            begin
                len = DAYS_FEB_LEAP;
            end
            else
            begin
                len = MONTH_DAYS[month];
            end
        end
        return len;
    endfunction

endpackage

`default_nettype wire

/* src/rtcc_in_stage.sv */
`default_nettype none

// Input register: hold one beat until the step stage can retire it.
module rtcc_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire rtcc_pkg::rtcc_item_t in_item,
    input  wire logic              drain,
    output logic                   item_valid,
    output rtcc_pkg::rtcc_item_t   item
);

    logic                 full_reg;
    logic                 full_next;
    rtcc_pkg::rtcc_item_t item_reg;
    logic                 advance;

    assign advance    = full_reg && drain;
    assign in_ready   = !full_reg || drain;
    assign item_valid = full_reg;
    assign item       = item_reg;

    always_comb
    begin
        full_next = full_reg;
        if (in_valid && in_ready)
        begin
            full_next = 1'b1;
        end
        else if (advance)
        begin
            full_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

/* src/rtcc_step.sv */
`default_nettype none

// Next time and date for one beat: a tick cascade or a clamped load.
module rtcc_step #(
    parameter int YEAR_WIDTH = 14
) (
    input  wire rtcc_pkg::rtcc_item_t item,
    input  wire rtcc_pkg::rtcc_time_t cur_tm,
    input  wire logic [YEAR_WIDTH-1:0] cur_year,
    output rtcc_pkg::rtcc_time_t      next_tm,
    output logic [YEAR_WIDTH-1:0]     next_year,
    output logic                      rolled
);

    rtcc_pkg::rtcc_time_t            tick_tm;
    logic [YEAR_WIDTH-1:0]           tick_year;
    logic                            sec_wrap;
    logic                            min_wrap;
    logic                            hour_wrap;
    logic                            midnight;
    logic                            cur_leap;
    logic [4:0]                      cur_len;

    rtcc_pkg::rtcc_time_t            load_tm;
    logic [rtcc_pkg::YEAR_MAX_WIDTH-1:0] set_year_ext;
    logic [YEAR_WIDTH-1:0]           load_year;
    logic [3:0]                      load_month;
    logic [4:0]                      load_len;

    // Tick: advance the cascade; the calendar moves only at midnight.
    always_comb
    begin
        sec_wrap  = (cur_tm.second >= rtcc_pkg::SECOND_MAX);
        min_wrap  = sec_wrap && (cur_tm.minute >= rtcc_pkg::MINUTE_MAX);
        hour_wrap = min_wrap && (cur_tm.hour >= rtcc_pkg::HOUR_MAX);
        midnight  = hour_wrap;
        cur_leap  = rtcc_pkg::is_leap(rtcc_pkg::YEAR_MAX_WIDTH'(cur_year));
        cur_len   = rtcc_pkg::month_length(cur_tm.month, cur_leap);

        tick_tm   = cur_tm;
        tick_year = cur_year;
        tick_tm.second = sec_wrap ? 6'd0 : cur_tm.second + 6'd1;
        if (sec_wrap)
        begin
            tick_tm.minute = min_wrap ? 6'd0 : cur_tm.minute + 6'd1;
        end
        if (min_wrap)
        begin
            tick_tm.hour = hour_wrap ? 5'd0 : cur_tm.hour + 5'd1;
        end
        if (midnight)
        begin
            if (cur_tm.day >= cur_len)
            begin
                tick_tm.day = rtcc_pkg::DAY_FIRST;
                if (cur_tm.month >= rtcc_pkg::MONTH_MAX)
                begin
                    tick_tm.month = rtcc_pkg::MONTH_FIRST;
                    tick_year     = cur_year + YEAR_WIDTH'(1);
                end
                else
                begin
                    tick_tm.month = cur_tm.month + 4'd1;
                end
            end
            else
            begin
                tick_tm.day = cur_tm.day + 5'd1;
            end
        end
    end

    // Load: clamp each field; the day is checked against the loaded month and year.
    always_comb
    begin
        set_year_ext   = rtcc_pkg::YEAR_MAX_WIDTH'(item.year);
        load_year      = set_year_ext[YEAR_WIDTH-1:0];
        load_tm.hour   = (item.tm.hour > rtcc_pkg::HOUR_MAX) ? 5'd0 : item.tm.hour;
        load_tm.minute = (item.tm.minute > rtcc_pkg::MINUTE_MAX) ? 6'd0 : item.tm.minute;
        load_tm.second = (item.tm.second > rtcc_pkg::SECOND_MAX) ? 6'd0 : item.tm.second;
        if (item.tm.month < rtcc_pkg::MONTH_FIRST || item.tm.month > rtcc_pkg::MONTH_MAX)
        begin
            load_month = rtcc_pkg::MONTH_FIRST;
        end
        else
        begin
            load_month = item.tm.month;
        end
        load_tm.month = load_month;
        load_len = rtcc_pkg::month_length(load_month,
            rtcc_pkg::is_leap(rtcc_pkg::YEAR_MAX_WIDTH'(load_year)));
        if (item.tm.day == 5'd0 || item.tm.day > load_len)
        begin
            load_tm.day = rtcc_pkg::DAY_FIRST;
        end
        else
        begin
            load_tm.day = item.tm.day;
        end
    end

    always_comb
    begin
        if (item.mode == rtcc_pkg::MODE_LOAD)
        begin
            next_tm   = load_tm;
            next_year = load_year;
            rolled    = 1'b0;
        end
        else
        begin
            next_tm   = tick_tm;
            next_year = tick_year;
            rolled    = midnight;
        end
    end

endmodule

`default_nettype wire

/* src/time_and_calendar_counter.sv */
// Real-time clock and Gregorian calendar. Each input beat is either a one-second tick
// (mode 0) or a load of the full time and date (mode 1); every beat yields exactly one
// output beat carrying the time and date after it, plus day_rolled, set when a tick
// crossed midnight. Loads clamp bad fields: hour above 23, minute or second above 59
// become 0, a month outside 1..12 becomes 1, and day 0 or a day past the month's length
// in the loaded year becomes 1. The year counts in YEAR_WIDTH bits (12..16) and wraps to
// 0 past its maximum; cur_year shows its low 14 bits and set_year is taken modulo
// 2^YEAR_WIDTH. After reset the clock reads 00:00:00, January 1, 1996. Throughput is one
// beat per clock while out_ready stays high: the tick cascade, month table lookup and leap
// test run combinationally between the input register and the result register. out_valid
// rises once the held input beat retires into the result register, which it does as soon
// as that register is free. While a finished result waits on out_ready the input register
// still takes one more beat, then in_ready drops until the waiting result is taken.
`default_nettype none

module time_and_calendar_counter #(
    parameter int YEAR_WIDTH = 14
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       mode,
    input  wire logic [4:0] set_hour,
    input  wire logic [5:0] set_minute,
    input  wire logic [5:0] set_second,
    input  wire logic [13:0] set_year,
    input  wire logic [3:0] set_month,
    input  wire logic [4:0] set_day,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [4:0]      cur_hour,
    output logic [5:0]      cur_minute,
    output logic [5:0]      cur_second,
    output logic [13:0]     cur_year,
    output logic [3:0]      cur_month,
    output logic [4:0]      cur_day,
    output logic            day_rolled
);

    localparam logic [YEAR_WIDTH-1:0] YEAR_RESET = YEAR_WIDTH'(rtcc_pkg::YEAR_RESET_VALUE);

    rtcc_pkg::rtcc_item_t in_item;
    rtcc_pkg::rtcc_item_t item;
    logic                 item_valid;
    logic                 drain;
    logic                 advance;

    // Calendar state: what the clock reads now.
    rtcc_pkg::rtcc_time_t  time_reg;
    logic [YEAR_WIDTH-1:0] year_reg;

    rtcc_pkg::rtcc_time_t  next_tm;
    logic [YEAR_WIDTH-1:0] next_year;
    logic                  rolled;
    logic [rtcc_pkg::YEAR_MAX_WIDTH-1:0] next_year_ext;

    // Result register.
    logic                  out_valid_reg;
    logic                  out_valid_next;
    rtcc_pkg::rtcc_time_t  res_tm_reg;
    logic [rtcc_pkg::SET_YEAR_WIDTH-1:0] res_year_reg;
    logic                  res_rolled_reg;

    // Pack the input ports into one beat.
    always_comb
    begin
        in_item.mode      = rtcc_pkg::mode_t'(mode);
        in_item.tm.hour   = set_hour;
        in_item.tm.minute = set_minute;
        in_item.tm.second = set_second;
        in_item.tm.month  = set_month;
        in_item.tm.day    = set_day;
        in_item.year      = set_year;
    end

    // The result register frees up when empty or when its beat is taken this cycle;
    // only then may the held input beat retire and update the calendar.
    assign drain   = !out_valid_reg || out_ready;
    assign advance = item_valid && drain;

    rtcc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .drain      (drain),
        .item_valid (item_valid),
        .item       (item)
    );

    rtcc_step #(
        .YEAR_WIDTH (YEAR_WIDTH)
    ) u_step (
        .item      (item),
        .cur_tm    (time_reg),
        .cur_year  (year_reg),
        .next_tm   (next_tm),
        .next_year (next_year),
        .rolled    (rolled)
    );

    // Advance the calendar state only when a beat retires.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg.hour   <= 5'd0;
            time_reg.minute <= 6'd0;
            time_reg.second <= 6'd0;
            time_reg.month  <= rtcc_pkg::MONTH_FIRST;
            time_reg.day    <= rtcc_pkg::DAY_FIRST;
            year_reg        <= YEAR_RESET;
        end
        else if (advance)
        begin
            time_reg <= next_tm;
            year_reg <= next_year;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Widen or trim the year to the 14-bit output field.
    assign next_year_ext = rtcc_pkg::YEAR_MAX_WIDTH'(next_year);

    // Payload holds while the result beat waits; no reset needed.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_tm_reg     <= next_tm;
            res_year_reg   <= next_year_ext[rtcc_pkg::SET_YEAR_WIDTH-1:0];
            res_rolled_reg <= rolled;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cur_hour   = res_tm_reg.hour;
    assign cur_minute = res_tm_reg.minute;
    assign cur_second = res_tm_reg.second;
    assign cur_year   = res_year_reg;
    assign cur_month  = res_tm_reg.month;
    assign cur_day    = res_tm_reg.day;
    assign day_rolled = res_rolled_reg;

`include "time_and_calendar_counter_macros.svh"

    // A rolled day is only ever reported at exactly midnight.
    `RTCC_ASSERT_IMPL(a_roll_at_midnight, out_valid && day_rolled,
        cur_hour == 5'd0 && cur_minute == 6'd0 && cur_second == 6'd0)

    // Time of day stays in range whatever was loaded.
    `RTCC_ASSERT_IMPL(a_time_in_range, 1'b1,
        time_reg.hour <= rtcc_pkg::HOUR_MAX && time_reg.minute <= rtcc_pkg::MINUTE_MAX &&
        time_reg.second <= rtcc_pkg::SECOND_MAX)

    // Month stays within 1..12 and the day never falls below 1.
    `RTCC_ASSERT_IMPL(a_date_in_range, 1'b1,
        time_reg.month >= rtcc_pkg::MONTH_FIRST && time_reg.month <= rtcc_pkg::MONTH_MAX &&
        time_reg.day >= rtcc_pkg::DAY_FIRST)

    // A retired beat shows up on the output matching the new calendar state.
    `RTCC_ASSERT_NEXT(a_result_tracks_state, advance,
        out_valid && cur_hour == time_reg.hour && cur_minute == time_reg.minute &&
        cur_second == time_reg.second && cur_day == time_reg.day &&
        cur_month == time_reg.month)

endmodule

`default_nettype wire

/* verif/calendar_checker.sv */
`default_nettype none

module calendar_checker #(
    parameter int YEAR_WIDTH = 14
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic        mode,
    input  wire logic [4:0]  set_hour,
    input  wire logic [5:0]  set_minute,
    input  wire logic [5:0]  set_second,
    input  wire logic [13:0] set_year,
    input  wire logic [3:0]  set_month,
    input  wire logic [4:0]  set_day,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [4:0]  cur_hour,
    input  wire logic [5:0]  cur_minute,
    input  wire logic [5:0]  cur_second,
    input  wire logic [13:0] cur_year,
    input  wire logic [3:0]  cur_month,
    input  wire logic [4:0]  cur_day,
    input  wire logic        day_rolled,
    output int               fail_count,
    output int               pending
);

    localparam int unsigned YEAR_WRAP_MASK = (1 << YEAR_WIDTH) - 1;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        rolled;
    } clock_reading_t;

    // Mirror of the clock and calendar, kept wide so that carries never wrap.
    int unsigned hour_q;
    int unsigned minute_q;
    int unsigned second_q;
    int unsigned day_q;
    int unsigned month_q;
    int unsigned year_q;

    clock_reading_t due_readings[$];
    int             errors;

    function automatic bit leap_year(input int unsigned y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned y, input int unsigned mon);
        case (mon)
            2:          return leap_year(y) ? 29 : 28;
            4, 6, 9, 11: return 30;
            default:    return 31;
        endcase
    endfunction

    function automatic string show_reading(input clock_reading_t r);
        return $sformatf("%02d:%02d:%02d %0d-%0d-%0d rolled=%0d",
                         r.hour, r.minute, r.second, r.year, r.month, r.day, r.rolled);
    endfunction

    // Apply one input beat to the mirror and return the reading it leaves.
    task automatic advance_calendar(
        input  logic           m,
        input  logic [4:0]     h,
        input  logic [5:0]     mi,
        input  logic [5:0]     s,
        input  logic [13:0]    y,
        input  logic [3:0]     mo,
        input  logic [4:0]     d,
        output clock_reading_t r
    );
        int unsigned new_month;
        int unsigned new_day;
        int unsigned new_year;
        logic        crossed;
        crossed = 1'b0;
        if (m == rtcc_pkg::MODE_LOAD)
        begin
            new_year  = int'(y) & YEAR_WRAP_MASK;
            new_month = (mo < 1 || mo > 12) ? 1 : mo;
            new_day   = (d == 0 || d > days_in_month(new_year, new_month)) ? 1 : d;
            hour_q    = (h > 23) ? 0 : h;
            minute_q  = (mi > 59) ? 0 : mi;
            second_q  = (s > 59) ? 0 : s;
            year_q    = new_year;
            month_q   = new_month;
            day_q     = new_day;
        end
        else
        begin
            second_q++;
            if (second_q > 59)
            begin
                second_q = 0;
                minute_q++;
            end
            if (minute_q > 59)
            begin
                minute_q = 0;
                hour_q++;
            end
            if (hour_q > 23)
            begin
                hour_q = 0;
            end
            if (hour_q == 0 && minute_q == 0 && second_q == 0)
            begin
                crossed = 1'b1;
                day_q++;
                if (day_q > days_in_month(year_q, month_q))
                begin
                    day_q = 1;
                    month_q++;
                end
                if (month_q > 12)
                begin
                    month_q = 1;
                    year_q  = (year_q + 1) & YEAR_WRAP_MASK;
                end
            end
        end
        r.hour   = 5'(hour_q);
        r.minute = 6'(minute_q);
        r.second = 6'(second_q);
        r.year   = 14'(year_q);
        r.month  = 4'(month_q);
        r.day    = 5'(day_q);
        r.rolled = crossed;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        clock_reading_t predicted;
        clock_reading_t observed;
        if (!rst_n)
        begin
            hour_q   = 0;
            minute_q = 0;
            second_q = 0;
            day_q    = 1;
            month_q  = 1;
            year_q   = rtcc_pkg::YEAR_RESET_VALUE & YEAR_WRAP_MASK;
            due_readings.delete();
            errors     = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_calendar(mode, set_hour, set_minute, set_second,
                                 set_year, set_month, set_day, predicted);
                due_readings.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                observed = '{cur_hour, cur_minute, cur_second, cur_year,
                             cur_month, cur_day, day_rolled};
                if (due_readings.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                    begin
                        $display("unexpected result beat: %s", show_reading(observed));
                    end
                end
                else
                begin
                    predicted = due_readings.pop_front();
                    if (observed !== predicted)
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                        begin
                            $display("result mismatch: expected %s, got %s",
                                     show_reading(predicted), show_reading(observed));
                        end
                    end
                end
            end
            fail_count <= errors;
            pending    <= due_readings.size();
        end
    end

endmodule

`default_nettype wire

/* verif/tb_time_and_calendar_counter.sv */
`default_nettype none

module tb_time_and_calendar_counter;

    // Stop criteria: directed beats first, then at least a third of this many random beats in each of three phases.
    localparam int RANDOM_BEATS = 1900;
    // Hard ceiling on the run, far above the slowest legal drain.
    localparam int CYCLE_LIMIT  = 400000;
    // Cycles to watch after the last result, well past the block's latency.
    localparam int TAIL_CYCLES  = 8;
    // Long receiver hold-off, to back the block up into its input side.
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int HOLD_OFF_AFTER  = 300;

    logic clk;
    logic rst_n = 1'b0;

    logic        in_valid   = 1'b0;
    logic        in_ready;
    logic        mode       = 1'b0;
    logic [4:0]  set_hour   = '0;
    logic [5:0]  set_minute = '0;
    logic [5:0]  set_second = '0;
    logic [13:0] set_year   = '0;
    logic [3:0]  set_month  = '0;
    logic [4:0]  set_day    = '0;

    logic        out_valid;
    logic        out_ready  = 1'b0;
    logic [4:0]  cur_hour;
    logic [5:0]  cur_minute;
    logic [5:0]  cur_second;
    logic [13:0] cur_year;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic        day_rolled;

    int fail_count;
    int pending;

    // Idle odds in percent per cycle, switched per phase by the stimulus.
    int send_idle_pct = 35;
    int recv_idle_pct = 62;
    logic hold_off    = 1'b0;
    int beats_sent    = 0;
    int cycles        = 0;

    time_and_calendar_counter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .set_hour   (set_hour),
        .set_minute (set_minute),
        .set_second (set_second),
        .set_year   (set_year),
        .set_month  (set_month),
        .set_day    (set_day),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cur_hour   (cur_hour),
        .cur_minute (cur_minute),
        .cur_second (cur_second),
        .cur_year   (cur_year),
        .cur_month  (cur_month),
        .cur_day    (cur_day),
        .day_rolled (day_rolled)
    );

    // The checker sits beside the block, watches both channels and keeps the score.
    calendar_checker calendar_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .mode       (mode),
        .set_hour   (set_hour),
        .set_minute (set_minute),
        .set_second (set_second),
        .set_year   (set_year),
        .set_month  (set_month),
        .set_day    (set_day),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cur_hour   (cur_hour),
        .cur_minute (cur_minute),
        .cur_second (cur_second),
        .cur_year   (cur_year),
        .cur_month  (cur_month),
        .cur_day    (cur_day),
        .day_rolled (day_rolled),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: end the run if the block hangs.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("tb_time_and_calendar_counter: FAIL");
        $finish;
    end

    // Receiver: drop ready at random per phase, and hold it low through the hold-off.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Hold off the receiver for a long stretch while the sender keeps offering beats,
    // so the block fills up and deasserts in_ready.
    initial
    begin
        while (beats_sent < HOLD_OFF_AFTER)
        begin
            @(posedge clk);
        end
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offer one beat: idle a random number of cycles first, then hold valid and the
    // payload steady until the beat is taken.
    task automatic send_beat(
        input logic        m,
        input logic [4:0]  h,
        input logic [5:0]  mi,
        input logic [5:0]  s,
        input logic [13:0] y,
        input logic [3:0]  mo,
        input logic [4:0]  d
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= m;
        set_hour   <= h;
        set_minute <= mi;
        set_second <= s;
        set_year   <= y;
        set_month  <= mo;
        set_day    <= d;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        beats_sent++;
    endtask

    task automatic load_beat(
        input logic [4:0]  h,
        input logic [5:0]  mi,
        input logic [5:0]  s,
        input logic [13:0] y,
        input logic [3:0]  mo,
        input logic [4:0]  d
    );
        send_beat(rtcc_pkg::MODE_LOAD, h, mi, s, y, mo, d);
    endtask

    // Advance one second; the set fields are don't-care, so scramble them.
    task automatic tick_beat();
        send_beat(rtcc_pkg::MODE_TICK, 5'($urandom), 6'($urandom), 6'($urandom),
                  14'($urandom), 4'($urandom), 5'($urandom));
    endtask

    // Drop valid and wait until every predicted beat has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        int          target;
        int          burst;
        int          pick;
        logic [13:0] yr;
        logic [4:0]  hr;
        logic [5:0]  mn;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes of the fields and every clamp and rollover corner.
        tick_beat();                                 // first second after reset
        load_beat(5'd0, 6'd0, 6'd0, 14'd0, 4'd0, 5'd0);   // all zero: month and day clamp
        load_beat(5'd31, 6'd63, 6'd63, 14'd16383, 4'd15, 5'd31);  // all ones
        load_beat(5'd24, 6'd60, 6'd60, 14'd2000, 4'd13, 5'd5);    // just past each time and month limit
        load_beat(5'd23, 6'd59, 6'd59, 14'd16383, 4'd12, 5'd31);  // year wraps to zero
        tick_beat();
        load_beat(5'd23, 6'd59, 6'd59, 14'd0, 4'd2, 5'd29);       // year zero is leap
        tick_beat();
        load_beat(5'd12, 6'd0, 6'd0, 14'd1900, 4'd2, 5'd29);      // century, not leap
        load_beat(5'd23, 6'd59, 6'd59, 14'd2000, 4'd2, 5'd29);    // quad century, leap
        tick_beat();
        load_beat(5'd23, 6'd59, 6'd59, 14'd2023, 4'd2, 5'd28);    // plain year, Feb end
        tick_beat();
        load_beat(5'd23, 6'd59, 6'd59, 14'd2024, 4'd2, 5'd28);    // leap year, Feb 28
        tick_beat();
        load_beat(5'd10, 6'd20, 6'd30, 14'd2021, 4'd4, 5'd31);    // past a 30-day month
        load_beat(5'd23, 6'd59, 6'd59, 14'd2021, 4'd4, 5'd30);    // end of a 30-day month
        tick_beat();
        load_beat(5'd0, 6'd58, 6'd59, 14'd2021, 4'd6, 5'd15);     // minute carry
        tick_beat();
        load_beat(5'd22, 6'd59, 6'd59, 14'd2021, 4'd6, 5'd15);    // hour carry
        tick_beat();
        load_beat(5'd23, 6'd59, 6'd59, 14'd2021, 4'd6, 5'd15);    // mid-month day carry
        tick_beat();

        // Random: three idling phases, each drained before the next starts.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 35;
                    recv_idle_pct = 62;
                end
                1:
                begin
                    send_idle_pct = 62;
                    recv_idle_pct = 35;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            target = beats_sent + RANDOM_BEATS / 3;
            while (beats_sent < target)
            begin
                pick = $urandom_range(99);
                if (pick < 75)
                begin
                    // Load just short of a rollover, then tick toward it and often across it.
                    case ($urandom_range(5))
                        0:       yr = 14'($urandom);
                        1:       yr = 14'($urandom_range(4095) * 4);
                        2:       yr = 14'($urandom_range(163) * 100);
                        3:       yr = 14'($urandom_range(40) * 400);
                        4:       yr = 14'd16383;
                        default: yr = 14'd0;
                    endcase
                    hr = ($urandom_range(99) < 70) ? 5'd23 : 5'($urandom_range(23));
                    mn = ($urandom_range(99) < 70) ? 6'd59 : 6'($urandom_range(59));
                    load_beat(hr, mn, 6'($urandom_range(45, 59)), yr,
                              4'($urandom_range(1, 12)), 5'($urandom_range(27, 31)));
                    burst = $urandom_range(1, 16);
                end
                else if (pick < 90)
                begin
                    // Noise: any bit pattern on every field.
                    load_beat(5'($urandom), 6'($urandom), 6'($urandom),
                              14'($urandom), 4'($urandom), 5'($urandom));
                    burst = $urandom_range(0, 4);
                end
                else
                begin
                    burst = $urandom_range(1, 8);
                end
                for (int i = 0; i < burst; i++)
                begin
                    tick_beat();
                end
            end
            // Pause the sender until every expected beat has come back.
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tb_time_and_calendar_counter: PASS");
        end
        else
        begin
            $display("tb_time_and_calendar_counter: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
